/* rtl/json_string_unescape_macros.svh */
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/jsu_pkg.sv */
package jsu_pkg;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
    localparam logic [2:0] ERR_TRUNCATED    = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX      = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN_ESC  = 3'd4;

    localparam int unsigned GROUP_DEPTH = 3;

    typedef struct packed {
        logic [1:0]                  count;
        logic [GROUP_DEPTH-1:0][7:0] data;
        logic [1:0]                  kind;
        logic [2:0]                  err;
    } group_t;

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c inside {[8'h30:8'h39]})
        begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

/* rtl/jsu_if.sv */
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last;

    modport source (output valid, output out_byte, output kind, output error_code,
                    output last, input ready);
    modport sink (input valid, input out_byte, input kind, input error_code,
                  input last, output ready);
endinterface

/* rtl/jsu_decode.sv */
module jsu_decode
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      text_byte,
    input  logic            text_end,
    output jsu_pkg::group_t grp
);

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESCAPE = 3'd1;
    localparam logic [2:0] MODE_HEX0   = 3'd2;
    localparam logic [2:0] MODE_HEX3   = 3'd5;

    logic [2:0]  mode_reg;
    logic [2:0]  mode_next;
    logic [15:0] acc_reg;
    logic [15:0] acc_next;
    logic [2:0]  mode_eff;
    logic [4:0]  hv;
    logic [15:0] code;

    assign mode_eff = (mode_reg > MODE_HEX3) ? MODE_NORMAL : mode_reg;
    assign hv       = jsu_pkg::hex_value(text_byte);
    assign code     = {acc_reg[11:0], hv[3:0]};

    always_comb
    begin
        grp       = '0;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        if (text_end)
        begin
            grp.count = 2'd1;
            grp.kind  = jsu_pkg::KIND_ERROR;
            grp.err   = (mode_eff >= MODE_HEX0) ? jsu_pkg::ERR_TRUNCATED
                                                : jsu_pkg::ERR_UNTERMINATED;
            mode_next = MODE_NORMAL;
        end
        else
        begin
            case (mode_eff)
                MODE_NORMAL:
                begin
                    if (text_byte == 8'h22)
                    begin
                        grp.count = 2'd1;
                        grp.kind  = jsu_pkg::KIND_CLOSE;
                    end
                    else if (text_byte == 8'h5C)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        grp.count   = 2'd1;
                        grp.data[0] = text_byte;
                    end
                end
                MODE_ESCAPE:
                begin
                    mode_next = MODE_NORMAL;
                    grp.count = 2'd1;
                    case (text_byte)
                        8'h22, 8'h5C, 8'h2F: grp.data[0] = text_byte;
                        8'h62: grp.data[0] = 8'h08;
                        8'h66: grp.data[0] = 8'h0C;
                        8'h6E: grp.data[0] = 8'h0A;
                        8'h72: grp.data[0] = 8'h0D;
                        8'h74: grp.data[0] = 8'h09;
                        8'h75:
                        begin
                            grp.count = 2'd0;
                            acc_next  = 16'h0000;
                            mode_next = MODE_HEX0;
                        end
                        default:
                        begin
                            grp.kind = jsu_pkg::KIND_ERROR;
                            grp.err  = jsu_pkg::ERR_UNKNOWN_ESC;
                        end
                    endcase
                end
                default:
                begin
                    if (!hv[4])
                    begin
                        mode_next = MODE_NORMAL;
                        grp.count = 2'd1;
                        grp.kind  = jsu_pkg::KIND_ERROR;
                        grp.err   = jsu_pkg::ERR_BAD_HEX;
                    end
                    else
                    begin
                        acc_next = code;
                        if (mode_eff != MODE_HEX3)
                        begin
                            mode_next = mode_eff + 3'd1;
                        end
                        else
                        begin
                            mode_next = MODE_NORMAL;
                            if (code < 16'h0080)
                            begin
                                grp.count   = 2'd1;
                                grp.data[0] = code[7:0];
                            end
                            else if (code < 16'h0800)
                            begin
                                grp.count   = 2'd2;
                                grp.data[0] = {3'b110, code[10:6]};
                                grp.data[1] = {2'b10, code[5:0]};
                            end
                            else
                            begin
                                grp.count   = 2'd3;
                                grp.data[0] = {4'b1110, code[15:12]};
                                grp.data[1] = {2'b10, code[11:6]};
                                grp.data[2] = {2'b10, code[5:0]};
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            acc_reg  <= 16'h0000;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

/* rtl/json_string_unescape.sv */
// channel  | dir | payload                              | per request
// ---------+-----+--------------------------------------+----------------------------
// text     | in  | text_byte[7:0], text_end             | one raw string body byte
// result   | out | out_byte[7:0], kind[1:0],            | one decoded byte, close
//          |     | error_code[2:0], last                | marker or error
//
// one text request per cycle while text.ready; a request makes 0 to 3 results,
// sent one per cycle while result.ready; a \u escape that yields two or three
// utf-8 bytes holds text off until the result group buffer is on its last entry
// rst_n clears the escape state and empties the result buffer
// result stalls back up into text once the last buffered result is waiting
module json_string_unescape
(
    input  logic       clk,
    input  logic       rst_n,
    jsu_in_if.sink     text,
    jsu_out_if.source  result
);

    jsu_pkg::group_t grp;
    jsu_pkg::group_t grp_reg;
    jsu_pkg::group_t grp_next;
    logic [1:0]      remain_reg;
    logic [1:0]      remain_next;
    logic [1:0]      pos_reg;
    logic [1:0]      pos_next;
    logic            take;
    logic            out_fire;

    assign text.ready = (remain_reg == 2'd0) || ((remain_reg == 2'd1) && result.ready);
    assign take       = text.valid && text.ready;
    assign out_fire   = result.valid && result.ready;

    jsu_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .text_byte (text.text_byte),
        .text_end  (text.text_end),
        .grp       (grp)
    );

    always_comb
    begin
        remain_next = remain_reg;
        pos_next    = pos_reg;
        grp_next    = grp_reg;
        if (take && (grp.count != 2'd0))
        begin
            remain_next = grp.count;
            pos_next    = 2'd0;
            grp_next    = grp;
        end
        else if (out_fire)
        begin
            remain_next = remain_reg - 2'd1;
            pos_next    = pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= 2'd0;
            pos_reg    <= 2'd0;
        end
        else
        begin
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    assign result.valid      = (remain_reg != 2'd0);
    assign result.out_byte   = grp_reg.data[pos_reg];
    assign result.kind       = grp_reg.kind;
    assign result.error_code = grp_reg.err;
    assign result.last       = (remain_reg == 2'd1);

endmodule

/* rtl/jsu_checker.sv */
`include "json_string_unescape_macros.svh"

module jsu_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [1:0] kind,
    input logic [2:0] error_code,
    input logic       last
);

    // close and error results stand alone
    `JSU_ASSERT_NOW(a_marker_last, out_valid && (kind != jsu_pkg::KIND_BYTE), last, "marker result without last")

    // error code is set exactly on error results
    `JSU_ASSERT_NOW(a_err_code, out_valid, (kind == jsu_pkg::KIND_ERROR) == (error_code != jsu_pkg::ERR_NONE), "error code does not match kind")

    // markers carry a zero byte
    `JSU_ASSERT_NOW(a_marker_zero, out_valid && (kind != jsu_pkg::KIND_BYTE), out_byte == 8'h00, "marker result with nonzero byte")

    // a multi-byte group continues without a gap
    `JSU_ASSERT_NEXT(a_group_cont, out_valid && out_ready && !last, out_valid && (kind == jsu_pkg::KIND_BYTE), "utf-8 group broken")

    // stalled result holds
    `JSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last), "stalled result changed")

endmodule

bind json_string_unescape jsu_checker u_jsu_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_byte   (result.out_byte),
    .kind       (result.kind),
    .error_code (result.error_code),
    .last       (result.last)
);
